// ----- src/mtsm_pkg.sv -----
`default_nettype none
package mtsm_pkg;

  localparam int FAULT_W = 7;
  localparam int CNT_W   = 32;
  localparam int TIME_W  = 32;
  localparam int TEN_W   = 18;
  localparam int SPD_W   = 15;
  localparam int PWM_W   = 10;
  localparam int CMD_W   = 3;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // fault mask bit positions
  localparam int F_OVERT  = 0;
  localparam int F_UNDERT = 1;
  localparam int F_OVERS  = 2;
  localparam int F_STALL  = 3;
  localparam int F_ENC    = 4;
  localparam int F_LOAD   = 5;
  localparam int F_ESTOP  = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_CHECK = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_RESET = 3'd3,
    CMD_ESTOP = 3'd4
  } cmd_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MAX_TENSION = 3'd0,
    REG_MIN_TENSION = 3'd1,
    REG_MAX_SPEED   = 3'd2,
    REG_WARN_LEVEL  = 3'd3,
    REG_STALL_TO    = 3'd4,
    REG_ENC_TO      = 3'd5
  } reg_idx_t;

  localparam logic [15:0] DEF_MAX_TENSION = 16'd10000;
  localparam logic [15:0] DEF_MIN_TENSION = 16'd500;
  localparam logic [13:0] DEF_MAX_SPEED   = 14'd2000;
  localparam logic [8:0]  DEF_WARN_LEVEL  = 9'd230;
  localparam logic [15:0] DEF_STALL_TO    = 16'd2000;
  localparam logic [15:0] DEF_ENC_TO      = 16'd2000;

  localparam logic [PWM_W-1:0] PWM_ENC_MIN   = 10'd150;
  localparam logic [PWM_W-1:0] PWM_STALL_MIN = 10'd300;
  localparam logic [SPD_W-1:0] STALL_SPEED   = 15'd10;

  function automatic logic [2:0] count_faults(input logic [FAULT_W-1:0] bits);
    logic [2:0] n;
    n = '0;
    for (int i = 0; i < FAULT_W; i++) begin
      n = n + {2'b0, bits[i]};
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ----- src/motor_tension_safety_monitor.sv -----
`default_nettype none
// Channel   Dir  Handshake               Payload
// s_axis    in   s_axis_tvalid/tready    tuser: cmd; tdata: sensor snapshot
// m_axis    out  m_axis_tvalid/tready    tdata: state, faults, count, accepted
// cfg       in   cfg_we                  cfg_addr, cfg_wdata (no read-back)
//
// One request in, one result out. A request is held in the input
// register, is evaluated in a single combinational pass and lands in the
// output register; a new request is taken every cycle unless the output stalls.
// rst is synchronous: limits return to defaults, state and fault count clear.
// A stalled output holds the input register; new requests wait only when both
// registers are full.
module motor_tension_safety_monitor (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  // [0] hw_estop, [1] loadcell_ok, [2] encoder_moving, [20:3] tension_g,
  // [35:21] speed, [45:36] pwm_permille, [77:46] time_ms, [79:78] zero
  input  wire  [mtsm_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // [2:0] cmd
  input  wire  [mtsm_pkg::CMD_W-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  // [2:0] sys_state, [9:3] fault_mask, [16:10] new_faults,
  // [48:17] faults_seen, [49] accepted, [55:50] zero
  output logic [mtsm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  wire                            cfg_we,
  input  wire  [mtsm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire  [mtsm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mtsm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_STARTING = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_STOPPING = 3'd3,
    ST_WARNING  = 3'd4,
    ST_FAULT    = 3'd5,
    ST_ESTOP    = 3'd6
  } mode_t;

  // configuration
  logic [15:0] max_tension, max_tension_next;
  logic [15:0] min_tension, min_tension_next;
  logic [13:0] max_speed, max_speed_next;
  logic [8:0]  warn_level, warn_level_next;
  logic [15:0] stall_to, stall_to_next;
  logic [15:0] enc_to, enc_to_next;
  logic [20:0] overt_lim;
  logic [20:0] undert_lim;
  logic [24:0] warn_t_lim;
  logic [22:0] warn_s_lim;

  always_comb begin
    max_tension_next = max_tension;
    min_tension_next = min_tension;
    max_speed_next   = max_speed;
    warn_level_next  = warn_level;
    stall_to_next    = stall_to;
    enc_to_next      = enc_to;
    if (rst) begin
      max_tension_next = DEF_MAX_TENSION;
      min_tension_next = DEF_MIN_TENSION;
      max_speed_next   = DEF_MAX_SPEED;
      warn_level_next  = DEF_WARN_LEVEL;
      stall_to_next    = DEF_STALL_TO;
      enc_to_next      = DEF_ENC_TO;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_MAX_TENSION: max_tension_next = cfg_wdata;
        REG_MIN_TENSION: min_tension_next = cfg_wdata;
        REG_MAX_SPEED:   max_speed_next   = cfg_wdata[13:0];
        REG_WARN_LEVEL:  warn_level_next  = cfg_wdata[8:0];
        REG_STALL_TO:    stall_to_next    = cfg_wdata;
        REG_ENC_TO:      enc_to_next      = cfg_wdata;
        default: ;
      endcase
    end
  end

  // limits and their scaled forms follow the register writes directly
  always_ff @(posedge clk) begin
    max_tension <= max_tension_next;
    min_tension <= min_tension_next;
    max_speed   <= max_speed_next;
    warn_level  <= warn_level_next;
    stall_to    <= stall_to_next;
    enc_to      <= enc_to_next;
    overt_lim   <= 21'({5'b0, max_tension_next} * 21'd21);
    undert_lim  <= 21'({5'b0, min_tension_next} * 21'd19);
    warn_t_lim  <= {16'b0, warn_level_next} * {9'b0, max_tension_next};
    warn_s_lim  <= {14'b0, warn_level_next} * {9'b0, max_speed_next};
  end

  // input register
  logic              in_valid;
  logic [CMD_W-1:0]  in_cmd;
  logic              in_estop;
  logic              in_load_ok;
  logic              in_enc_moving;
  logic [TEN_W-1:0]  in_tension;
  logic [SPD_W-1:0]  in_speed;
  logic [PWM_W-1:0]  in_pwm;
  logic [TIME_W-1:0] in_time;

  logic advance;
  logic fire;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign fire          = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd        <= s_axis_tuser;
      in_estop      <= s_axis_tdata[0];
      in_load_ok    <= s_axis_tdata[1];
      in_enc_moving <= s_axis_tdata[2];
      in_tension    <= s_axis_tdata[20:3];
      in_speed      <= s_axis_tdata[35:21];
      in_pwm        <= s_axis_tdata[45:36];
      in_time       <= s_axis_tdata[77:46];
    end
  end

  // supervisor state
  mode_t              mode, mode_next;
  logic [FAULT_W-1:0] fault_bits, fault_bits_next;
  logic [TIME_W-1:0]  enc_seen, enc_seen_next;
  logic [TIME_W-1:0]  stall_began, stall_began_next;
  logic               stalling, stalling_next;
  logic [CNT_W-1:0]   fault_tally, fault_tally_next;
  logic [FAULT_W-1:0] fresh;
  logic               ok;

  logic signed [26:0] tx;
  logic signed [26:0] t20;
  logic signed [26:0] t256;
  logic [SPD_W-1:0]   abs_speed;
  logic [22:0]        s256;
  logic [TIME_W-1:0]  enc_diff;
  logic [TIME_W-1:0]  stall_diff;

  always_comb begin
    tx         = {{(27-TEN_W){in_tension[TEN_W-1]}}, in_tension};
    t20        = tx * 27'sd20;
    t256       = tx <<< 8;
    abs_speed  = in_speed[SPD_W-1] ? (~in_speed + 15'd1) : in_speed;
    s256       = {abs_speed, 8'b0};
    enc_diff   = in_time - enc_seen;
    stall_diff = in_time - stall_began;
  end

  always_comb begin
    mode_next        = mode;
    fault_bits_next  = fault_bits;
    enc_seen_next    = enc_seen;
    stall_began_next = stall_began;
    stalling_next    = stalling;
    ok               = 1'b0;

    case (cmd_t'(in_cmd))
      CMD_CHECK: begin
        ok = 1'b1;
        if (in_estop) begin
          fault_bits_next[F_ESTOP] = 1'b1;
          mode_next = ST_ESTOP;
        end else begin
          fault_bits_next[F_ESTOP] = 1'b0;
          fault_bits_next[F_LOAD]  = !in_load_ok;

          if (!in_enc_moving && mode == ST_RUNNING && in_pwm > PWM_ENC_MIN) begin
            if (enc_diff > {16'b0, enc_to}) begin
              fault_bits_next[F_ENC] = 1'b1;
            end
          end else begin
            enc_seen_next = in_time;
            fault_bits_next[F_ENC] = 1'b0;
          end

          if (mode_next == ST_STARTING && fault_bits_next == '0) begin
            mode_next = ST_RUNNING;
          end

          if (mode_next inside {ST_RUNNING, ST_WARNING}) begin
            if (t20 > $signed({6'b0, overt_lim})) begin
              fault_bits_next[F_OVERT] = 1'b1;
            end else if (tx < $signed({11'b0, max_tension})) begin
              fault_bits_next[F_OVERT] = 1'b0;
            end

            if (t20 < $signed({6'b0, undert_lim}) && tx > 27'sd10) begin
              fault_bits_next[F_UNDERT] = 1'b1;
            end else if (tx > $signed({11'b0, min_tension})) begin
              fault_bits_next[F_UNDERT] = 1'b0;
            end

            fault_bits_next[F_OVERS] = abs_speed > {1'b0, max_speed};

            if (abs_speed < STALL_SPEED && in_pwm > PWM_STALL_MIN) begin
              if (!stalling) begin
                stall_began_next = in_time;
                stalling_next    = 1'b1;
              end else if (stall_diff > {16'b0, stall_to}) begin
                fault_bits_next[F_STALL] = 1'b1;
              end
            end else begin
              stalling_next = 1'b0;
              fault_bits_next[F_STALL] = 1'b0;
            end

            if (t256 > $signed({2'b0, warn_t_lim}) || s256 > warn_s_lim) begin
              if (fault_bits_next == '0) begin
                mode_next = ST_WARNING;
              end
            end else if (mode_next == ST_WARNING && fault_bits_next == '0) begin
              mode_next = ST_RUNNING;
            end
          end

          if (fault_bits_next != '0 && mode_next != ST_ESTOP) begin
            mode_next = ST_FAULT;
          end else if (fault_bits_next == '0 &&
                       (mode_next == ST_FAULT || mode_next == ST_ESTOP)) begin
            mode_next = ST_IDLE;
          end
        end
      end
      CMD_START: begin
        if (mode == ST_IDLE && fault_bits == '0) begin
          mode_next = ST_STARTING;
          ok = 1'b1;
        end
      end
      CMD_STOP: begin
        if (mode inside {ST_RUNNING, ST_WARNING}) begin
          mode_next = ST_STOPPING;
          ok = 1'b1;
        end
      end
      CMD_RESET: begin
        if (mode inside {ST_FAULT, ST_ESTOP}) begin
          fault_bits_next = '0;
          mode_next       = ST_IDLE;
          stalling_next   = 1'b0;
          ok = 1'b1;
        end
      end
      CMD_ESTOP: begin
        fault_bits_next[F_ESTOP] = 1'b1;
        mode_next = ST_ESTOP;
        ok = 1'b1;
      end
      default: ;
    endcase

    // each fault bit is touched at most once per request
    fresh            = fault_bits_next & ~fault_bits;
    fault_tally_next = fault_tally + {29'b0, count_faults(fresh)};
  end

  // output register
  logic [2:0]         out_state;
  logic [FAULT_W-1:0] out_mask;
  logic [FAULT_W-1:0] out_new;
  logic [CNT_W-1:0]   out_tally;
  logic               out_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= ST_IDLE;
      fault_bits    <= '0;
      enc_seen      <= '0;
      stall_began   <= '0;
      stalling      <= 1'b0;
      fault_tally   <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        m_axis_tvalid <= in_valid;
      end
      if (fire) begin
        mode          <= mode_next;
        fault_bits    <= fault_bits_next;
        enc_seen      <= enc_seen_next;
        stall_began   <= stall_began_next;
        stalling      <= stalling_next;
        fault_tally   <= fault_tally_next;
      end
    end
    if (fire) begin
      out_state <= mode_next;
      out_mask  <= fault_bits_next;
      out_new   <= fresh;
      out_tally <= fault_tally_next;
      out_ok    <= ok;
    end
  end

  assign m_axis_tdata = {6'b0, out_ok, out_tally, out_new, out_mask, out_state};

  // fault count moves only with a processed request
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(fire) |-> $stable(fault_tally))
    else $error("fault count changed without a request");

  // a hardware or software e-stop fault always holds the ESTOP state
  assert property (@(posedge clk) disable iff (rst)
    fault_bits[F_ESTOP] |-> mode == ST_ESTOP)
    else $error("e-stop fault outside ESTOP state");

  // newly raised faults are part of the reported mask
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_new & ~out_mask) == '0)
    else $error("new fault missing from fault mask");

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 100ps
module tb;
  import mtsm_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_STARTING = 3'd1;
  localparam logic [2:0] ST_RUNNING  = 3'd2;
  localparam logic [2:0] ST_STOPPING = 3'd3;
  localparam logic [2:0] ST_WARNING  = 3'd4;
  localparam logic [2:0] ST_FAULT    = 3'd5;
  localparam logic [2:0] ST_ESTOP    = 3'd6;

  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;
  localparam longint UNDERT_FLOOR_G = 10;

  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic                    estop;
    logic                    loadcell_ok;
    logic                    enc_moving;
    logic signed [TEN_W-1:0] tension;
    logic signed [SPD_W-1:0] speed;
    logic [PWM_W-1:0]        pwm;
    logic [TIME_W-1:0]       now;
  } sensor_req_t;

  typedef struct {
    logic [2:0]         state;
    logic [FAULT_W-1:0] faults;
    logic [FAULT_W-1:0] fresh;
    logic [CNT_W-1:0]   tally;
    logic               accepted;
  } status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // [0] hw_estop, [1] loadcell_ok, [2] encoder_moving, [20:3] tension_g,
  // [35:21] speed, [45:36] pwm_permille, [77:46] time_ms, [79:78] zero
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  // [2:0] cmd
  logic [CMD_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // [2:0] sys_state, [9:3] fault_mask, [16:10] new_faults,
  // [48:17] faults_seen, [49] accepted, [55:50] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // limit registers as last written
  logic [15:0] lim_max_tension = DEF_MAX_TENSION;
  logic [15:0] lim_min_tension = DEF_MIN_TENSION;
  logic [13:0] lim_max_speed   = DEF_MAX_SPEED;
  logic [8:0]  lim_warn_q8     = DEF_WARN_LEVEL;
  logic [15:0] lim_stall_ms    = DEF_STALL_TO;
  logic [15:0] lim_enc_ms      = DEF_ENC_TO;

  // supervisor state as predicted
  logic [2:0]         mon_mode       = ST_IDLE;
  logic [FAULT_W-1:0] mon_faults     = '0;
  logic [FAULT_W-1:0] mon_fresh      = '0;
  logic [TIME_W-1:0]  enc_seen_ms    = '0;
  logic [TIME_W-1:0]  stall_began_ms = '0;
  logic               stalling       = 1'b0;
  logic [CNT_W-1:0]   fault_tally    = '0;

  status_t pending_status[$];
  status_t oldest;
  int mismatch_count = 0;
  int burst_left = 0;
  bit sender_gaps = 1'b1;
  int scenario = 0;
  logic [TIME_W-1:0] sim_ms = '0;
  logic [7:0]  ready_cycle = '0;
  logic [1:0]  ready_mode = '0;
  logic [15:0] ready_pattern = '1;

  motor_tension_safety_monitor dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int jitter(input int n);
    return int'($urandom_range(0, 2 * n)) - n;
  endfunction

  function automatic void latch_fault(input int b);
    if (!mon_faults[b]) begin
      mon_faults[b] = 1'b1;
      mon_fresh[b] = 1'b1;
      fault_tally = fault_tally + 1;
    end
  endfunction

  function automatic void run_checks(input sensor_req_t r);
    longint t, aspd, mx, mn, ms, wl;
    logic [TIME_W-1:0] enc_age, stall_age;
    t = r.tension;
    aspd = r.speed;
    if (aspd < 0) aspd = -aspd;
    mx = lim_max_tension;
    mn = lim_min_tension;
    ms = lim_max_speed;
    wl = lim_warn_q8;
    enc_age = r.now - enc_seen_ms;
    stall_age = r.now - stall_began_ms;

    if (r.estop) begin
      latch_fault(F_ESTOP);
      mon_mode = ST_ESTOP;
      return;
    end
    mon_faults[F_ESTOP] = 1'b0;

    if (!r.loadcell_ok) latch_fault(F_LOAD);
    else mon_faults[F_LOAD] = 1'b0;

    if (!r.enc_moving && mon_mode == ST_RUNNING && r.pwm > PWM_ENC_MIN) begin
      if (enc_age > lim_enc_ms) latch_fault(F_ENC);
    end else begin
      enc_seen_ms = r.now;
      mon_faults[F_ENC] = 1'b0;
    end

    if (mon_mode == ST_STARTING && mon_faults == '0) mon_mode = ST_RUNNING;

    if (mon_mode == ST_RUNNING || mon_mode == ST_WARNING) begin
      if (20 * t > 21 * mx) latch_fault(F_OVERT);
      else if (t < mx) mon_faults[F_OVERT] = 1'b0;

      if (20 * t < 19 * mn && t > UNDERT_FLOOR_G) latch_fault(F_UNDERT);
      else if (t > mn) mon_faults[F_UNDERT] = 1'b0;

      if (aspd > ms) latch_fault(F_OVERS);
      else mon_faults[F_OVERS] = 1'b0;

      if (aspd < STALL_SPEED && r.pwm > PWM_STALL_MIN) begin
        if (!stalling) begin
          stall_began_ms = r.now;
          stalling = 1'b1;
        end else if (stall_age > lim_stall_ms) begin
          latch_fault(F_STALL);
        end
      end else begin
        stalling = 1'b0;
        mon_faults[F_STALL] = 1'b0;
      end

      if (256 * t > wl * mx || 256 * aspd > wl * ms) begin
        if (mon_faults == '0) mon_mode = ST_WARNING;
      end else if (mon_mode == ST_WARNING && mon_faults == '0) begin
        mon_mode = ST_RUNNING;
      end
    end

    if (mon_faults != '0 && mon_mode != ST_ESTOP) begin
      mon_mode = ST_FAULT;
    end else if (mon_faults == '0 && (mon_mode == ST_FAULT || mon_mode == ST_ESTOP)) begin
      mon_mode = ST_IDLE;
    end
  endfunction

  function automatic status_t predict_status(input sensor_req_t r);
    status_t s;
    s.accepted = 1'b0;
    mon_fresh = '0;
    case (r.cmd)
      CMD_CHECK: begin
        run_checks(r);
        s.accepted = 1'b1;
      end
      CMD_START: if (mon_mode == ST_IDLE && mon_faults == '0) begin
        mon_mode = ST_STARTING;
        s.accepted = 1'b1;
      end
      CMD_STOP: if (mon_mode == ST_RUNNING || mon_mode == ST_WARNING) begin
        mon_mode = ST_STOPPING;
        s.accepted = 1'b1;
      end
      CMD_RESET: if (mon_mode == ST_FAULT || mon_mode == ST_ESTOP) begin
        mon_faults = '0;
        mon_mode = ST_IDLE;
        stalling = 1'b0;
        s.accepted = 1'b1;
      end
      CMD_ESTOP: begin
        latch_fault(F_ESTOP);
        mon_mode = ST_ESTOP;
        s.accepted = 1'b1;
      end
      default: ;
    endcase
    s.state = mon_mode;
    s.faults = mon_faults;
    s.fresh = mon_fresh;
    s.tally = fault_tally;
    return s;
  endfunction

  function automatic sensor_req_t mk_req(input logic [CMD_W-1:0] cmd, input logic estop,
                                         input logic lc_ok, input logic enc, input int t,
                                         input int s, input int pwm,
                                         input logic [TIME_W-1:0] now);
    sensor_req_t r;
    r.cmd = cmd;
    r.estop = estop;
    r.loadcell_ok = lc_ok;
    r.enc_moving = enc;
    r.tension = t[TEN_W-1:0];
    r.speed = s[SPD_W-1:0];
    r.pwm = pwm[PWM_W-1:0];
    r.now = now;
    return r;
  endfunction

  // commands follow the predicted state so most traffic walks the normal
  // start/run/fault/reset path; sensor values cluster on the thresholds
  function automatic sensor_req_t random_request();
    sensor_req_t r;
    longint mx, mn, ms, wl, v;
    logic signed [TEN_W-1:0] raw_t;
    logic signed [SPD_W-1:0] raw_s;
    int pick, span;
    mx = lim_max_tension;
    mn = lim_min_tension;
    ms = lim_max_speed;
    wl = lim_warn_q8;
    raw_t = TEN_W'($urandom);
    raw_s = SPD_W'($urandom);

    pick = int'($urandom_range(0, 99));
    if (pick < 3) r.cmd = CMD_UNUSED_FIRST + 3'($urandom_range(0, 2));
    else if (pick < 6) r.cmd = CMD_ESTOP;
    else if (mon_mode == ST_IDLE) r.cmd = (pick < 55) ? CMD_START : CMD_CHECK;
    else if (mon_mode == ST_FAULT || mon_mode == ST_ESTOP)
      r.cmd = (pick < 40) ? CMD_RESET : CMD_CHECK;
    else if (pick < 12) r.cmd = CMD_STOP;
    else if (pick < 15) r.cmd = CMD_START;
    else if (pick < 18) r.cmd = CMD_RESET;
    else r.cmd = CMD_CHECK;

    if ($urandom_range(0, 19) == 0) scenario = int'($urandom_range(0, 3));
    r.estop = ($urandom_range(0, 99) < 3);
    r.loadcell_ok = ($urandom_range(0, 99) >= 5);
    case (scenario)
      1: begin  // blocked rotor
        r.enc_moving = 1'($urandom_range(0, 1));
        r.pwm = PWM_W'($urandom_range(250, 1000));
        span = int'(lim_stall_ms);
      end
      2: begin  // dead encoder
        r.enc_moving = ($urandom_range(0, 9) == 0);
        r.pwm = PWM_W'($urandom_range(100, 1000));
        span = int'(lim_enc_ms);
      end
      default: begin
        r.enc_moving = ($urandom_range(0, 9) != 0);
        r.pwm = PWM_W'($urandom_range(0, 1000));
        span = 40;
      end
    endcase

    case ($urandom_range(0, 7))
      0: v = raw_t;
      1: v = (21 * mx) / 20 + jitter(2);
      2: v = mx + jitter(2);
      3: v = (19 * mn) / 20 + jitter(2);
      4: v = mn + jitter(2);
      5: v = (wl * mx) / 256 + jitter(2);
      6: v = UNDERT_FLOOR_G + jitter(2);
      default: v = (mx > mn) ? mn + $urandom_range(0, int'(mx - mn)) : mn;
    endcase
    r.tension = v[TEN_W-1:0];

    pick = (scenario == 1) ? 0 : int'($urandom_range(0, 4));
    case (pick)
      0: v = jitter(12);
      1: v = raw_s;
      2: v = ms + jitter(2);
      3: v = (wl * ms) / 256 + jitter(2);
      default: v = $urandom_range(0, int'(ms));
    endcase
    if ($urandom_range(0, 1)) v = -v;
    r.speed = v[SPD_W-1:0];

    case ($urandom_range(0, 19))
      0: sim_ms = $urandom;
      1: sim_ms = stall_began_ms + lim_stall_ms + jitter(1);
      2: sim_ms = enc_seen_ms + lim_enc_ms + jitter(1);
      default: sim_ms = sim_ms + $urandom_range(0, span / 2 + 20);
    endcase
    r.now = sim_ms;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  task automatic send_request(input sensor_req_t r);
    if (sender_gaps && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, r.now, r.pwm, r.speed, r.tension,
                     r.enc_moving, r.loadcell_ok, r.estop};
    s_axis_tuser <= r.cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_status.push_back(predict_status(r));
  endtask

  task automatic send_cmd(input logic [CMD_W-1:0] cmd);
    sensor_req_t r;
    r = random_request();
    r.cmd = cmd;
    send_request(r);
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_limits(input logic [15:0] max_t, input logic [15:0] min_t,
                                input logic [15:0] max_s, input logic [15:0] warn,
                                input logic [15:0] stall_to, input logic [15:0] enc_to);
    logic [CFG_DATA_W-1:0] vals [6];
    vals = '{max_t, min_t, max_s, warn, stall_to, enc_to};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= reg_idx_t'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      case (reg_idx_t'(i))
        REG_MAX_TENSION: lim_max_tension = vals[i];
        REG_MIN_TENSION: lim_min_tension = vals[i];
        REG_MAX_SPEED:   lim_max_speed = vals[i][13:0];
        REG_WARN_LEVEL:  lim_warn_q8 = vals[i][8:0];
        REG_STALL_TO:    lim_stall_ms = vals[i];
        REG_ENC_TO:      lim_enc_ms = vals[i];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  task automatic test_command_rules();
    send_cmd(CMD_UNUSED_LAST);
    send_cmd(CMD_STOP);
    send_cmd(CMD_RESET);
    send_cmd(CMD_START);
    send_cmd(CMD_START);
    send_request(mk_req(CMD_CHECK, 1'b0, 1'b1, 1'b1, 5000, 100, 200, 32'd1000));
    send_request(mk_req(CMD_CHECK, 1'b0, 1'b1, 1'b1, 9500, 100, 200, 32'd1010));
    send_request(mk_req(CMD_CHECK, 1'b0, 1'b1, 1'b1, 5000, 100, 200, 32'd1020));
    send_cmd(CMD_STOP);
    send_request(mk_req(CMD_CHECK, 1'b0, 1'b0, 1'b1, 5000, 0, 0, 32'd1030));
    send_request(mk_req(CMD_CHECK, 1'b0, 1'b1, 1'b1, 5000, 0, 0, 32'd1040));
  endtask

  task automatic test_fault_paths();
    send_cmd(CMD_START);
    send_request(mk_req(CMD_CHECK, 1'b0, 1'b1, 1'b1, -131072, 16383, 0, 32'hFFFFFF00));
    send_request(mk_req(CMD_CHECK, 1'b0, 1'b1, 1'b0, 131071, -16384, 1000, 32'hFFFFFFFF));
    send_cmd(CMD_ESTOP);
    send_request(mk_req(CMD_CHECK, 1'b1, 1'b1, 1'b1, 5000, 0, 0, 32'd0));
    // e-stop released but over-speed still latched: stays in e-stop
    send_request(mk_req(CMD_CHECK, 1'b0, 1'b1, 1'b1, 5000, 0, 0, 32'd5));
    send_cmd(CMD_RESET);
    send_cmd(CMD_START);
    send_request(mk_req(CMD_CHECK, 1'b0, 1'b1, 1'b1, 5000, 5, 400, 32'hFFFFFF00));
    // timestamps wrap: stall, encoder and under-tension all trip together
    send_request(mk_req(CMD_CHECK, 1'b0, 1'b1, 1'b0, 20, 0, 1000, 32'h00000700));
    send_cmd(CMD_RESET);
    send_cmd(CMD_START);
    send_request(mk_req(CMD_CHECK, 1'b1, 1'b1, 1'b1, 5000, 0, 0, 32'h00000800));
    send_request(mk_req(CMD_CHECK, 1'b0, 1'b1, 1'b1, 5000, 0, 0, 32'h00000810));
  endtask

  task automatic test_random_traffic(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) sender_gaps = ($urandom_range(0, 3) != 0);
      send_request(random_request());
    end
  endtask

  task automatic test_limit_settings();
    wait_for_drain();
    program_limits(16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0);
    test_random_traffic(170);
    wait_for_drain();
    program_limits(16'hFFFF, 16'hFFFF, 16'd16383, 16'd256, 16'hFFFF, 16'hFFFF);
    test_random_traffic(170);
    wait_for_drain();
    program_limits(16'd1200, 16'd300, 16'd250, 16'd128, 16'd40, 16'd40);
    test_random_traffic(170);
    wait_for_drain();
    program_limits(16'($urandom), 16'($urandom), 16'($urandom_range(1, 16383)),
                   16'($urandom_range(0, 256)), 16'($urandom_range(0, 3000)),
                   16'($urandom_range(0, 3000)));
    test_random_traffic(170);
    wait_for_drain();
    program_limits(DEF_MAX_TENSION, DEF_MIN_TENSION, {2'b0, DEF_MAX_SPEED},
                   {7'b0, DEF_WARN_LEVEL}, DEF_STALL_TO, DEF_ENC_TO);
    test_random_traffic(170);
  endtask

  always @(posedge clk) begin
    ready_cycle <= ready_cycle + 8'd1;
    if (ready_cycle[5:0] == '0) begin
      ready_mode <= 2'($urandom_range(0, 3));
      ready_pattern <= 16'($urandom);
    end
    case (ready_mode)
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
      2'd2: m_axis_tready <= ready_pattern[ready_cycle[3:0]];
      default: m_axis_tready <= (ready_cycle[2:0] != 3'd0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_status.size() == 0) begin
        report_mismatch("result with none pending", m_axis_tdata, 0);
      end else begin
        oldest = pending_status.pop_front();
        if (m_axis_tdata[2:0] != oldest.state)
          report_mismatch("sys_state", m_axis_tdata[2:0], oldest.state);
        if (m_axis_tdata[9:3] != oldest.faults)
          report_mismatch("fault_mask", m_axis_tdata[9:3], oldest.faults);
        if (m_axis_tdata[16:10] != oldest.fresh)
          report_mismatch("new_faults", m_axis_tdata[16:10], oldest.fresh);
        if (m_axis_tdata[48:17] != oldest.tally)
          report_mismatch("faults_seen", m_axis_tdata[48:17], oldest.tally);
        if (m_axis_tdata[49] != oldest.accepted)
          report_mismatch("accepted", m_axis_tdata[49], oldest.accepted);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_command_rules();
    test_fault_paths();
    test_random_traffic(150);
    test_limit_settings();
    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
